// ===== hdl/sws_pkg.sv =====
// Shared types, constants and codes of the sliding-window sender.
package sws_pkg;

  localparam int WINDOW_LIMIT = 3;
  localparam int PAYLOAD_BITS = 64;
  localparam int PORT_PAYLOAD_BITS = 64;
  localparam int SEQ_BITS = 2;
  localparam int SEQ_DEPTH = 4;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [PAYLOAD_BITS-1:0] data_t;
  typedef logic [PORT_PAYLOAD_BITS-1:0] port_data_t;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  wr_en;
    seq_t  wr_addr;
    data_t wr_data;
    seq_t  rd_addr;
  } ram_req_t;

endpackage

// ===== hdl/sws_in_if.sv =====
// Input channel: commands, payloads and acknowledgements toward the sender.
interface sws_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic [sws_pkg::PORT_PAYLOAD_BITS-1:0] payload;
  logic [1:0]                          ack_number;
  logic                                ack_checksum_ok;

  modport source (output valid, output command, output payload, output ack_number,
                  output ack_checksum_ok, input ready);
  modport sink (input valid, input command, input payload, input ack_number,
                input ack_checksum_ok, output ready);
endinterface

// ===== hdl/sws_out_if.sv =====
// Result channel: packets to transmit and timer requests from the sender.
interface sws_out_if;
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic                                packet_valid;
  logic [1:0]                          packet_seq;
  logic [sws_pkg::PORT_PAYLOAD_BITS-1:0] packet_payload;
  logic [1:0]                          timer_action;
  logic                                last;

  modport source (output valid, output accepted, output packet_valid, output packet_seq,
                  output packet_payload, output timer_action, output last, input ready);
  modport sink (input valid, input accepted, input packet_valid, input packet_seq,
                input packet_payload, input timer_action, input last, output ready);
endinterface

// ===== hdl/sws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sws_seq.sv =====
// Sequencer and window state of the sender; drives the payload store and the result register.
module sws_seq (
  input  logic                clk,
  input  logic                rst_n,
  sws_in_if.sink              in_ch,
  sws_out_if.source           out_ch,
  output sws_pkg::ram_req_t   ram_req,
  input  sws_pkg::data_t      ram_rd_data
);

  sws_pkg::state_t state_r, state_nxt;
  sws_pkg::seq_t   base_r, base_nxt;
  sws_pkg::seq_t   next_seq_r, next_seq_nxt;
  logic [1:0]      fill_r, fill_nxt;
  sws_pkg::seq_t   prev_ack_r, prev_ack_nxt;
  logic [1:0]      dup_r, dup_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  logic [1:0]      cmd_r;
  sws_pkg::data_t  data_r;
  sws_pkg::seq_t   ack_r;
  logic            ok_r;

  logic               o_acc_r, o_acc_nxt;
  logic               o_pv_r, o_pv_nxt;
  sws_pkg::seq_t      o_seq_r, o_seq_nxt;
  sws_pkg::port_data_t o_payload_r, o_payload_nxt;
  logic [1:0]         o_timer_r, o_timer_nxt;
  logic               o_last_r, o_last_nxt;

  sws_pkg::seq_t target;
  sws_pkg::seq_t span;
  logic [1:0]    dup_inc;
  logic [1:0]    fill_left;
  sws_pkg::seq_t cnt_seq;

  assign target    = ack_r + 2'd1;
  assign span      = target - base_r;
  assign dup_inc   = dup_r + 2'd1;
  assign fill_left = fill_r - span;
  assign cnt_seq   = base_r + cnt_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sws_pkg::ST_IDLE;
      base_r     <= '0;
      next_seq_r <= '0;
      fill_r     <= '0;
      prev_ack_r <= '0;
      dup_r      <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      base_r     <= base_nxt;
      next_seq_r <= next_seq_nxt;
      fill_r     <= fill_nxt;
      prev_ack_r <= prev_ack_nxt;
      dup_r      <= dup_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r  <= in_ch.command;
      data_r <= in_ch.payload[sws_pkg::PAYLOAD_BITS-1:0];
      ack_r  <= in_ch.ack_number;
      ok_r   <= in_ch.ack_checksum_ok;
    end
    o_acc_r     <= o_acc_nxt;
    o_pv_r      <= o_pv_nxt;
    o_seq_r     <= o_seq_nxt;
    o_payload_r <= o_payload_nxt;
    o_timer_r   <= o_timer_nxt;
    o_last_r    <= o_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    next_seq_nxt  = next_seq_r;
    fill_nxt      = fill_r;
    prev_ack_nxt  = prev_ack_r;
    dup_nxt       = dup_r;
    cnt_nxt       = cnt_r;
    o_acc_nxt     = o_acc_r;
    o_pv_nxt      = o_pv_r;
    o_seq_nxt     = o_seq_r;
    o_payload_nxt = o_payload_r;
    o_timer_nxt   = o_timer_r;
    o_last_nxt    = o_last_r;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = next_seq_r;
    ram_req.wr_data = data_r;
    ram_req.rd_addr = target;

    case (state_r)
      sws_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = sws_pkg::ST_EXEC;
        end
      end

      sws_pkg::ST_EXEC: begin
        // Every result starts out empty and final; the cases below fill it in.
        o_acc_nxt     = 1'b0;
        o_pv_nxt      = 1'b0;
        o_seq_nxt     = '0;
        o_payload_nxt = '0;
        o_timer_nxt   = sws_pkg::TMR_NONE;
        o_last_nxt    = 1'b1;
        state_nxt     = sws_pkg::ST_OUT;
        case (cmd_r)
          sws_pkg::CMD_SEND: begin
            if (fill_r < 2'(sws_pkg::WINDOW_LIMIT)) begin
              ram_req.wr_en = 1'b1;
              o_acc_nxt     = 1'b1;
              o_pv_nxt      = 1'b1;
              o_seq_nxt     = next_seq_r;
              o_payload_nxt[sws_pkg::PAYLOAD_BITS-1:0] = data_r;
              o_timer_nxt   = (fill_r == 2'd0) ? sws_pkg::TMR_START : sws_pkg::TMR_NONE;
              next_seq_nxt  = next_seq_r + 2'd1;
              fill_nxt      = fill_r + 2'd1;
            end
          end

          sws_pkg::CMD_ACK: begin
            if (ok_r) begin
              if (ack_r == prev_ack_r && dup_inc == 2'd3) begin
                // Third repeat of the same acknowledgement: fast retransmit.
                dup_nxt = '0;
                if (span < fill_r) begin
                  o_pv_nxt  = 1'b1;
                  o_seq_nxt = target;
                  state_nxt = sws_pkg::ST_READ;
                end
              end else begin
                if (ack_r == prev_ack_r) begin
                  dup_nxt = dup_inc;
                end else begin
                  prev_ack_nxt = ack_r;
                  dup_nxt      = '0;
                end
                if (span <= fill_r) begin
                  base_nxt    = target;
                  fill_nxt    = fill_left;
                  o_timer_nxt = (fill_left == 2'd0) ? sws_pkg::TMR_STOP
                                                    : sws_pkg::TMR_RESTART;
                end else begin
                  o_timer_nxt = (fill_r == 2'd0) ? sws_pkg::TMR_STOP
                                                 : sws_pkg::TMR_RESTART;
                end
              end
            end
          end

          sws_pkg::CMD_TIMEOUT: begin
            o_timer_nxt = sws_pkg::TMR_RESTART;
            if (fill_r != 2'd0) begin
              cnt_nxt         = '0;
              ram_req.rd_addr = base_r;
              o_pv_nxt        = 1'b1;
              o_seq_nxt       = base_r;
              o_last_nxt      = (fill_r == 2'd1);
              state_nxt       = sws_pkg::ST_READ;
            end
          end

          default: begin
          end
        endcase
      end

      sws_pkg::ST_READ: begin
        o_payload_nxt = '0;
        o_payload_nxt[sws_pkg::PAYLOAD_BITS-1:0] = ram_rd_data;
        state_nxt = sws_pkg::ST_OUT;
      end

      sws_pkg::ST_OUT: begin
        if (out_ch.ready) begin
          if (o_last_r) begin
            state_nxt = sws_pkg::ST_IDLE;
          end else begin
            // Next buffered packet of a timeout resend, oldest first.
            cnt_nxt         = cnt_r + 2'd1;
            ram_req.rd_addr = cnt_seq;
            o_seq_nxt       = cnt_seq;
            o_timer_nxt     = sws_pkg::TMR_NONE;
            o_last_nxt      = ({1'b0, cnt_r} + 3'd2 == {1'b0, fill_r});
            state_nxt       = sws_pkg::ST_READ;
          end
        end
      end

      default: begin
        state_nxt = sws_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready           = (state_r == sws_pkg::ST_IDLE);
  assign out_ch.valid          = (state_r == sws_pkg::ST_OUT);
  assign out_ch.accepted       = o_acc_r;
  assign out_ch.packet_valid   = o_pv_r;
  assign out_ch.packet_seq     = o_seq_r;
  assign out_ch.packet_payload = o_payload_r;
  assign out_ch.timer_action   = o_timer_r;
  assign out_ch.last           = o_last_r;

endmodule

// ===== hdl/sliding_window_sender_fast_retx.sv =====
// Top level of the go-back-N sender with fast retransmit.
//
//   channel   direction  handshake        word
//   in_ch     sink       valid / ready    command, payload, ack_number, ack_checksum_ok
//   out_ch    source     valid / ready    accepted, packet_valid, packet_seq,
//                                         packet_payload, timer_action, last
//
// A word without a packet read passes through accept, execute and present; a fast
// retransmit and each buffered packet of a timeout resend add a read of the
// payload store, which has one read port. The block takes one word at a time.
// Reset is synchronous and clears the window state; the payload store is not cleared.
// While a result waits for out_ch.ready, the block holds it and takes no new word.
module sliding_window_sender_fast_retx (
  input  logic       clk,
  input  logic       rst_n,
  sws_in_if.sink     in_ch,
  sws_out_if.source  out_ch
);

  sws_pkg::ram_req_t ram_req;
  sws_pkg::data_t    ram_rd_data;

  sws_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  sws_ram #(
    .WIDTH (sws_pkg::PAYLOAD_BITS),
    .DEPTH (sws_pkg::SEQ_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again right after a word was accepted");

  a_hold_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> !in_ch.ready)
    else $error("input taken before the last result was delivered");

  a_no_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> !out_ch.valid && !in_ch.ready)
    else $error("payload store written outside the execute step");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.packet_valid |-> out_ch.packet_seq == 2'd0 &&
      out_ch.packet_payload == '0)
    else $error("result without a packet carries packet data");

  a_accept_has_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.accepted |-> out_ch.packet_valid && out_ch.last)
    else $error("accepted send without its packet");

endmodule
